FILE: rtl/btd_pkg.sv
package btd_pkg;

  localparam logic [7:0] LEAD_LO   = 8'hC2;
  localparam logic [7:0] LEAD_HI   = 8'hC5;
  localparam logic [7:0] CONT_LO   = 8'h80;
  localparam logic [7:0] CONT_HI   = 8'hBF;
  localparam logic [7:0] C3_OFS    = 8'h40;
  localparam logic [7:0] C4_SPLIT  = 8'hA0;
  localparam logic [7:0] C4_GAP    = 8'hA1;
  localparam logic [7:0] C4_GAP_B  = 8'h7F;
  localparam logic [7:0] C4_OFS_HI = 8'h22;
  localparam logic [7:0] C5_B0     = 8'h9E;
  localparam logic [7:0] C5_B1     = 8'h9F;
  localparam logic [7:0] C5_B2     = 8'hA0;
  localparam logic [7:0] C5_B3     = 8'hAD;

  // lead selector: held lead minus C2
  localparam logic [1:0] SEL_C2 = 2'd0;
  localparam logic [1:0] SEL_C3 = 2'd1;
  localparam logic [1:0] SEL_C4 = 2'd2;
  localparam logic [1:0] SEL_C5 = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       msg_end;
  } btd_res_t;

  typedef struct packed {
    logic [1:0] cnt;
    btd_res_t   res0;
    btd_res_t   res1;
    logic       pend_nxt;
    logic [1:0] held_nxt;
  } btd_dec_t;

  // returns {valid, raw byte} for a lead selector and continuation byte
  function automatic logic [8:0] pair_map(input logic [1:0] sel, input logic [7:0] nc);
    logic       ok;
    logic [7:0] b;
    begin
      ok = (nc >= CONT_LO) && (nc <= CONT_HI);
      b  = nc;
      case (sel)
        SEL_C2: b = nc;
        SEL_C3: b = nc + C3_OFS;
        SEL_C4: begin
          if (nc <= C4_SPLIT) begin
            b = nc - CONT_LO;
          end else if (nc == C4_GAP) begin
            b = C4_GAP_B;
          end else begin
            b = nc - C4_OFS_HI;
          end
        end
        SEL_C5: begin
          case (nc[1:0])
            2'd0:    b = C5_B0;
            2'd1:    b = C5_B1;
            2'd2:    b = C5_B2;
            default: b = C5_B3;
          endcase
          ok = ok && (nc[7:2] == CONT_LO[7:2]);
        end
        default: b = nc;
      endcase
      pair_map = {ok, b};
    end
  endfunction

endpackage

FILE: rtl/byte_level_token_text_decoder.sv
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall   | in_byte, in_msg_last
// out     | output    | out_valid / out_stall | out_byte, out_run_last, out_msg_end
//
// One input byte per cycle while in_stall is low.
// Decode runs in one pass from the input register into a 4-entry result queue.
// A byte that yields two results writes both into the queue; the queue absorbs them.
// Input stalls only while the queue holds more than two results.
// rst_n (synchronous) clears the held lead, the input stage and the queue.
module byte_level_token_text_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_msg_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_msg_end
);
  import btd_pkg::*;

  logic       stg_v_r, stg_v_nxt;
  logic [7:0] stg_data_r;
  logic       stg_last_r;
  logic       pend_r;
  logic [1:0] held_r;
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r, cnt_nxt;
  btd_res_t   q_r [4];
  btd_dec_t   dec;
  logic       room;
  logic       go;
  logic       in_xfer;
  logic       pop;
  logic [1:0] push_n;

  btd_decode u_dec (
    .in_data (stg_data_r),
    .in_last (stg_last_r),
    .pend    (pend_r),
    .held    (held_r),
    .dec     (dec)
  );

  assign room     = (cnt_r <= 3'd2);
  assign go       = stg_v_r && room;
  assign in_stall = stg_v_r && !room;
  assign in_xfer  = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;
  assign push_n   = go ? dec.cnt : 2'd0;

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (in_xfer) begin
      stg_v_nxt = 1'b1;
    end else if (go) begin
      stg_v_nxt = 1'b0;
    end
    cnt_nxt = cnt_r + {1'b0, push_n} - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r  <= 1'b0;
      pend_r   <= 1'b0;
      held_r   <= 2'd0;
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      stg_v_r  <= stg_v_nxt;
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_r + push_n;
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      if (go) begin
        pend_r <= dec.pend_nxt;
        held_r <= dec.held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stg_data_r <= in_byte;
      stg_last_r <= in_msg_last;
    end
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= dec.res0;
    end
    if (push_n == 2'd2) begin
      q_r[wr_ptr_r + 2'd1] <= dec.res1;
    end
  end

  assign out_valid    = (cnt_r != 3'd0);
  assign out_byte     = q_r[rd_ptr_r].data;
  assign out_run_last = q_r[rd_ptr_r].run_last;
  assign out_msg_end  = q_r[rd_ptr_r].msg_end;

endmodule

FILE: rtl/btd_decode.sv
module btd_decode (
  input  logic              [7:0] in_data,
  input  logic                    in_last,
  input  logic                    pend,
  input  logic              [1:0] held,
  output btd_pkg::btd_dec_t       dec
);
  import btd_pkg::*;

  logic [8:0] pm;
  logic       is_lead;

  always_comb begin
    pm      = pair_map(held, in_data);
    is_lead = (in_data inside {[LEAD_LO:LEAD_HI]}) && !in_last;

    dec          = '0;
    dec.pend_nxt = pend;
    dec.held_nxt = held;

    if (pend && pm[8]) begin
      dec.cnt      = 2'd1;
      dec.res0     = '{data: pm[7:0], run_last: 1'b1, msg_end: in_last};
      dec.pend_nxt = 1'b0;
    end else if (pend) begin
      // held lead goes out as is, current byte handled afresh
      dec.res0.data = LEAD_LO + {6'd0, held};
      if (is_lead) begin
        dec.cnt           = 2'd1;
        dec.res0.run_last = 1'b1;
        dec.held_nxt      = in_data[1:0] - LEAD_LO[1:0];
      end else begin
        dec.cnt      = 2'd2;
        dec.res1     = '{data: in_data, run_last: 1'b1, msg_end: in_last};
        dec.pend_nxt = 1'b0;
      end
    end else if (is_lead) begin
      dec.pend_nxt = 1'b1;
      dec.held_nxt = in_data[1:0] - LEAD_LO[1:0];
    end else begin
      dec.cnt  = 2'd1;
      dec.res0 = '{data: in_data, run_last: 1'b1, msg_end: in_last};
    end
  end

endmodule

FILE: rtl/btd_checker.sv
module btd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_msg_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte)
      && $stable(out_run_last) && $stable(out_msg_end))
    else $error("stalled result changed");

  a_end_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_msg_end |-> out_run_last)
    else $error("message end on a non-final result");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind byte_level_token_text_decoder btd_checker u_btd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_byte     (out_byte),
  .out_run_last (out_run_last),
  .out_msg_end  (out_msg_end)
);
